/* src/vas_pkg.sv */
// shared constants, types and the frame-to-step expansion of the volume attenuator writer
package vas_pkg;

  localparam int StepCycles = 10;
  localparam int FrameBits  = 11;
  localparam int NumSteps   = 4 * FrameBits + 3;
  localparam int TimerW     = $clog2(StepCycles + 1);
  localparam int VolW       = 8;
  localparam int AttW       = 7;

  localparam logic [AttW-1:0] AttMax     = 7'd83;
  localparam logic [VolW-1:0] VolFull    = 8'd100;
  localparam logic [4:0]      CoarseBase = 5'd21;
  localparam logic [1:0]      FineBase   = 2'b11;
  localparam logic [1:0]      StopBits   = 2'b11;
  localparam int              RecipShift = 19;
  localparam logic [18:0]     RecipMul   = 19'd435169;

  typedef logic [FrameBits-1:0] frame_t;

  typedef struct packed {
    logic last;
    logic dat;
    logic clk;
  } step_t;

  typedef step_t [NumSteps-1:0] steps_t;

  function automatic steps_t steps_of(frame_t frame);
    steps_t s;
    s[0] = '{last: 1'b0, dat: 1'b0, clk: 1'b0};
    for (int i = 0; i < FrameBits; i++) begin
      s[1 + 4 * i] = '{last: 1'b0, dat: 1'b0, clk: (i != 0)};
      s[2 + 4 * i] = '{last: 1'b0, dat: 1'b0, clk: 1'b0};
      s[3 + 4 * i] = '{last: 1'b0, dat: frame[i], clk: 1'b0};
      s[4 + 4 * i] = '{last: 1'b0, dat: frame[i], clk: 1'b1};
    end
    s[NumSteps-2] = '{last: 1'b0, dat: 1'b1, clk: 1'b1};
    s[NumSteps-1] = '{last: 1'b1, dat: 1'b1, clk: 1'b0};
    return s;
  endfunction

endpackage

/* src/vas_frame.sv */
// volume to attenuation mapping and 11-bit frame assembly
module vas_frame
  import vas_pkg::*;
(
  input  logic            channel_i,
  input  logic [VolW-1:0] volume_percent_i,
  output frame_t          frame_o
);

  logic [VolW+18:0] prod;
  logic [AttW-1:0]  scaled;
  logic [AttW-1:0]  att;
  logic [4:0]       coarse;
  logic [1:0]       fine;

  // floor(v * 83 / 100) through a reciprocal multiply
  assign prod   = {19'd0, volume_percent_i} * {{VolW{1'b0}}, RecipMul};
  assign scaled = prod[RecipShift +: AttW];
  assign att    = (volume_percent_i > VolFull) ? '0 : AttMax - scaled;
  assign coarse = CoarseBase - att[AttW-1:2];
  assign fine   = FineBase - att[1:0];

  assign frame_o = {StopBits, fine, coarse, 1'b1, channel_i};

endmodule

/* src/vas_cell.sv */
// one stage of the step shift chain
module vas_cell
  import vas_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic  shift_i,
  input  step_t load_step_i,
  input  logic  next_valid_i,
  input  step_t next_step_i,
  output logic  valid_o,
  output step_t step_o
);

  logic  valid_q;
  step_t step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (shift_i) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      step_q <= load_step_i;
    end else if (shift_i) begin
      step_q <= next_step_i;
    end
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;

endmodule

/* src/volume_attenuator_serial_writer.sv */
// top level of the two-wire volume attenuator serial writer
//
// usage:
// - slave side takes one volume request: tuser carries the channel select,
//   tdata carries the volume percent (values above 100 mean loudest)
// - master side gives 47 pin steps per request, one per transfer, with the
//   clock level in tdata bit 0, the data level in tdata bit 1, and tlast
//   high on the closing latch step
// - a step is offered only when the step hold timer, restarted by every step
//   transfer, has counted down to zero, so each pin level is held for the
//   timer period; a receiver stall holds it longer
// - on an idle block a taken request is stored in the holding register and
//   then loaded into the chain, whose first cell offers the first step
// - one request waits in a holding register while a frame is shifting out,
//   so the next request is taken while the current one is still running
// - the step chain is a row of 47 cells; a frame loads in parallel and
//   shifts one cell toward the output on each step transfer
// - a receiver stall simply freezes the chain and the current step
// - reset empties the holding register and the chain; no clearing pass
module volume_attenuator_serial_writer
  import vas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // volume_percent[7:0]
  input  logic       s_axis_tuser,   // channel
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // clock_level, data_level, zero pad[7:2]
  output logic       m_axis_tlast    // last_step
);

  logic              s_accept;
  logic              m_accept;
  logic              load;
  frame_t            frame_in;
  logic              hold_vld_q;
  frame_t            hold_frame_q;
  logic [TimerW-1:0] wait_q;
  logic [TimerW-1:0] wait_d;
  steps_t            load_steps;
  logic   [NumSteps-1:0] cell_valid;
  step_t  [NumSteps-1:0] cell_step;

  vas_frame u_frame (
    .channel_i        (s_axis_tuser),
    .volume_percent_i (s_axis_tdata),
    .frame_o          (frame_in)
  );

  assign s_axis_tready = !hold_vld_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign load          = hold_vld_q && !cell_valid[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (s_accept) begin
      hold_vld_q <= 1'b1;
    end else if (load) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      hold_frame_q <= frame_in;
    end
  end

  assign load_steps = steps_of(hold_frame_q);

  for (genvar k = 0; k < NumSteps; k++) begin : g_cell
    logic  nxt_valid;
    step_t nxt_step;
    if (k == NumSteps - 1) begin : g_end
      assign nxt_valid = 1'b0;
      assign nxt_step  = '0;
    end else begin : g_mid
      assign nxt_valid = cell_valid[k+1];
      assign nxt_step  = cell_step[k+1];
    end
    vas_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load),
      .shift_i      (m_accept),
      .load_step_i  (load_steps[k]),
      .next_valid_i (nxt_valid),
      .next_step_i  (nxt_step),
      .valid_o      (cell_valid[k]),
      .step_o       (cell_step[k])
    );
  end

  // step hold timer
  always_comb begin
    wait_d = wait_q;
    if (m_accept) begin
      wait_d = TimerW'(StepCycles - 1);
    end else if (wait_q != '0) begin
      wait_d = wait_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
    end else begin
      wait_q <= wait_d;
    end
  end

  assign m_axis_tvalid = cell_valid[0] && (wait_q == '0);
  assign m_axis_tdata  = {6'd0, cell_step[0].dat, cell_step[0].clk};
  assign m_axis_tlast  = cell_step[0].last;

  a_hold_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> hold_vld_q)
    else $error("request accepted but holding register empty");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_accept && m_axis_tlast) |=> !cell_valid[0])
    else $error("chain not empty after latch step");

  a_load_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cell_valid[0] && !m_axis_tlast && cell_valid[NumSteps-1]))
    else $error("frame load did not fill the chain");

  a_timer_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_accept |=> (wait_q == TimerW'(StepCycles - 1)))
    else $error("hold timer not restarted after step");

endmodule
